[hw/rtl/sbv_pkg.sv]
// Shared types and constants for the shifting blitter video store.
`default_nettype none
package sbv_pkg;

    localparam int VRAM_ADDR_BITS = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 5;

    localparam logic [1:0] ACT_BLIT      = 2'd0;
    localparam logic [1:0] ACT_COL_WRITE = 2'd1;
    localparam logic [1:0] ACT_FETCH     = 2'd2;
    localparam logic [1:0] ACT_VID_READ  = 2'd3;

    localparam logic [3:0] MODE_REPLACE = 4'd0;
    localparam logic [3:0] MODE_OR      = 4'd1;
    localparam logic [3:0] MODE_ERASE   = 4'd13;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SHIFT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FLIP  = 2'd3;

    localparam logic [VRAM_ADDR_BITS-1:0] PAIR_STRIDE = 13'h100;
    localparam logic [7:0]                FLIP_Y_OFFSET = 8'd32;

    typedef struct packed {
        logic [1:0]                action;
        logic [VRAM_ADDR_BITS-1:0] address;
        logic [7:0]                data;
        logic [7:0]                pixel_x;
        logic [7:0]                pixel_y;
    } t_request;

    typedef struct packed {
        logic [7:0] read_data;
        logic [5:0] pixel_color;
        logic       mode_ignored;
    } t_result;

    typedef struct packed {
        logic [2:0] shift_amount;
        logic [3:0] blit_mode;
        logic [4:0] draw_color;
        logic       flip_view;
    } t_cfg;

    typedef struct packed {
        logic                      vid_en;
        logic                      vid_we;
        logic [VRAM_ADDR_BITS-1:0] vid_addr;
        logic [7:0]                vid_wdata;
        logic                      col_en;
        logic                      col_we;
        logic [VRAM_ADDR_BITS-1:0] col_addr;
        logic [4:0]                col_wdata;
    } t_mem_req;

endpackage
`default_nettype wire

[hw/rtl/sbv_store.sv]
// Video byte and colour code memories, single port each, registered read.
`default_nettype none
module sbv_store (
    input  wire              i_clk,
    input  sbv_pkg::t_mem_req i_mem,
    output logic [7:0]       o_vid_rdata,
    output logic [4:0]       o_col_rdata
);

    localparam int DEPTH = 1 << sbv_pkg::VRAM_ADDR_BITS;

    logic [7:0] r_vid_mem [DEPTH];
    logic [4:0] r_col_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_mem.vid_en) begin
            if (i_mem.vid_we) begin
                r_vid_mem[i_mem.vid_addr] <= i_mem.vid_wdata;
            end else begin
                o_vid_rdata <= r_vid_mem[i_mem.vid_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem.col_en) begin
            if (i_mem.col_we) begin
                r_col_mem[i_mem.col_addr] <= i_mem.col_wdata;
            end else begin
                o_col_rdata <= r_col_mem[i_mem.col_addr];
            end
        end
    end

endmodule
`default_nettype wire

[hw/rtl/sbv_ctrl.sv]
// Request sequencer: clearing pass, blit read-modify-write, colour writes, reads and fetches.
`default_nettype none
module sbv_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  sbv_pkg::t_request  i_request,
    input  sbv_pkg::t_cfg      i_cfg,
    input  wire [7:0]          i_vid_rdata,
    input  wire [4:0]          i_col_rdata,
    output sbv_pkg::t_mem_req  o_mem,
    output logic               o_busy,
    output logic               o_strobe,
    output sbv_pkg::t_result   o_result
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_B_RDLO = 3'd2;
    localparam logic [2:0] S_B_MOD  = 3'd3;
    localparam logic [2:0] S_B_WRLO = 3'd4;
    localparam logic [2:0] S_RD     = 3'd5;

    localparam logic [sbv_pkg::VRAM_ADDR_BITS-1:0] LAST_ADDR = '1;

    logic [2:0]                          r_state, n_state;
    logic [sbv_pkg::VRAM_ADDR_BITS-1:0]  r_clr_addr, n_clr_addr;
    logic                                r_strobe, n_strobe;
    sbv_pkg::t_result                    r_result, n_result;
    sbv_pkg::t_request                   r_req, n_req;
    logic [7:0]                          r_hi, n_hi;
    logic [7:0]                          r_lo_new, n_lo_new;
    logic                                r_stamp_lo, n_stamp_lo;
    logic [2:0]                          r_bitsel, n_bitsel;

    logic [7:0]                          fx, fy;
    logic [sbv_pkg::VRAM_ADDR_BITS-1:0]  fetch_addr;
    logic [sbv_pkg::VRAM_ADDR_BITS-1:0]  lo_addr;
    logic [15:0]                         shifted, mask, word, word_new;
    logic                                mode_ok;

    always_comb begin
        fx = i_cfg.flip_view ? ~i_request.pixel_x : i_request.pixel_x;
        fy = i_cfg.flip_view ? (~i_request.pixel_y + sbv_pkg::FLIP_Y_OFFSET)
                             : i_request.pixel_y;
        fetch_addr = {fx[7:3], fy};
        lo_addr    = r_req.address + sbv_pkg::PAIR_STRIDE;
        shifted    = {r_req.data, 8'h00} >> i_cfg.shift_amount;
        mask       = 16'hff00 >> i_cfg.shift_amount;
        word       = {r_hi, i_vid_rdata};
        mode_ok    = 1'b1;
        unique case (i_cfg.blit_mode)
            sbv_pkg::MODE_REPLACE: word_new = (word & ~mask) | shifted;
            sbv_pkg::MODE_OR:      word_new = word | shifted;
            sbv_pkg::MODE_ERASE:   word_new = word & ~shifted;
            default: begin
                word_new = word;
                mode_ok  = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_strobe   = 1'b0;
        n_result   = r_result;
        n_req      = r_req;
        n_hi       = r_hi;
        n_lo_new   = r_lo_new;
        n_stamp_lo = r_stamp_lo;
        n_bitsel   = r_bitsel;
        o_mem      = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_mem.vid_en   = 1'b1;
                o_mem.vid_we   = 1'b1;
                o_mem.vid_addr = r_clr_addr;
                o_mem.col_en   = 1'b1;
                o_mem.col_we   = 1'b1;
                o_mem.col_addr = r_clr_addr;
                n_clr_addr     = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req    = i_request;
                    n_bitsel = ~fx[2:0];
                    unique case (i_request.action)
                        sbv_pkg::ACT_BLIT: begin
                            o_mem.vid_en   = 1'b1;
                            o_mem.vid_addr = i_request.address;
                            n_state        = S_B_RDLO;
                        end
                        sbv_pkg::ACT_COL_WRITE: begin
                            o_mem.col_en    = 1'b1;
                            o_mem.col_we    = 1'b1;
                            o_mem.col_addr  = i_request.address;
                            o_mem.col_wdata = i_request.data[4:0];
                            n_strobe        = 1'b1;
                            n_result        = '0;
                        end
                        sbv_pkg::ACT_FETCH: begin
                            o_mem.vid_en   = 1'b1;
                            o_mem.vid_addr = fetch_addr;
                            o_mem.col_en   = 1'b1;
                            o_mem.col_addr = fetch_addr;
                            n_state        = S_RD;
                        end
                        default: begin
                            o_mem.vid_en   = 1'b1;
                            o_mem.vid_addr = i_request.address;
                            n_state        = S_RD;
                        end
                    endcase
                end
            end
            S_B_RDLO: begin
                n_hi           = i_vid_rdata;
                o_mem.vid_en   = 1'b1;
                o_mem.vid_addr = lo_addr;
                n_state        = S_B_MOD;
            end
            S_B_MOD: begin
                if (mode_ok) begin
                    o_mem.vid_en    = 1'b1;
                    o_mem.vid_we    = 1'b1;
                    o_mem.vid_addr  = r_req.address;
                    o_mem.vid_wdata = word_new[15:8];
                    o_mem.col_en    = (i_cfg.blit_mode != sbv_pkg::MODE_ERASE)
                                      && (shifted[15:8] != 8'h00);
                    o_mem.col_we    = 1'b1;
                    o_mem.col_addr  = r_req.address;
                    o_mem.col_wdata = i_cfg.draw_color;
                    n_lo_new        = word_new[7:0];
                    n_stamp_lo      = (i_cfg.blit_mode != sbv_pkg::MODE_ERASE)
                                      && (shifted[7:0] != 8'h00);
                    n_state         = S_B_WRLO;
                end else begin
                    n_strobe              = 1'b1;
                    n_result              = '0;
                    n_result.mode_ignored = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            S_B_WRLO: begin
                o_mem.vid_en    = 1'b1;
                o_mem.vid_we    = 1'b1;
                o_mem.vid_addr  = lo_addr;
                o_mem.vid_wdata = r_lo_new;
                o_mem.col_en    = r_stamp_lo;
                o_mem.col_we    = 1'b1;
                o_mem.col_addr  = lo_addr;
                o_mem.col_wdata = i_cfg.draw_color;
                n_strobe        = 1'b1;
                n_result        = '0;
                n_state         = S_IDLE;
            end
            S_RD: begin
                n_strobe = 1'b1;
                n_result = '0;
                if (r_req.action == sbv_pkg::ACT_FETCH) begin
                    n_result.pixel_color = {i_vid_rdata[r_bitsel], i_col_rdata};
                end else begin
                    n_result.read_data = i_vid_rdata;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result   <= n_result;
        r_req      <= n_req;
        r_hi       <= n_hi;
        r_lo_new   <= n_lo_new;
        r_stamp_lo <= n_stamp_lo;
        r_bitsel   <= n_bitsel;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

[hw/rtl/shift_blit_video_ram.sv]
// A colour write is done from idle; a read or fetch registers its result; a
// blit reads and writes both bytes (two reads and two writes through the single
// video memory port), with no write for an unsupported mode. No start is taken
// while busy; busy falls as the one-cycle result strobe rises, and the receiver
// cannot stall. Reset zeroes both memories, busy high meanwhile; configuration
// registers reset to zero, to be written only when idle; this is not enforced.
`default_nettype none
module shift_blit_video_ram (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    input  sbv_pkg::t_request                   i_request,
    output logic                                busy,
    output logic                                o_strobe,
    output sbv_pkg::t_result                    o_result,
    input  wire                                 i_cfg_we,
    input  wire [sbv_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire [sbv_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    sbv_pkg::t_cfg     r_cfg;
    sbv_pkg::t_mem_req mem_req;
    logic [7:0]        vid_rdata;
    logic [4:0]        col_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sbv_pkg::REG_SHIFT: r_cfg.shift_amount <= i_cfg_data[2:0];
                sbv_pkg::REG_MODE:  r_cfg.blit_mode    <= i_cfg_data[3:0];
                sbv_pkg::REG_COLOR: r_cfg.draw_color   <= i_cfg_data[4:0];
                default:            r_cfg.flip_view    <= i_cfg_data[0];
            endcase
        end
    end

    sbv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_request   (i_request),
        .i_cfg       (r_cfg),
        .i_vid_rdata (vid_rdata),
        .i_col_rdata (col_rdata),
        .o_mem       (mem_req),
        .o_busy      (busy),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    sbv_store u_store (
        .i_clk       (i_clk),
        .i_mem       (mem_req),
        .o_vid_rdata (vid_rdata),
        .o_col_rdata (col_rdata)
    );

endmodule
`default_nettype wire
